// File: rtl/dwd_pkg.sv
// ----------------------------------------------------------------------------
// Distance waypoint decimator package
// Shared types, constants and helpers for the waypoint decimator.
// ----------------------------------------------------------------------------
package dwd_pkg;

   localparam int POS_W     = 32;
   localparam int HEADING_W = 16;
   localparam int INDEX_W   = 16;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;

   localparam int DIFF_W = POS_W + 1;
   localparam int AXIS_W = 24;
   localparam int RAD_W  = 2 * AXIS_W;
   localparam int ROOT_W = AXIS_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W);
   localparam int TRAV_W = 26;

   localparam logic [CSR_W-1:0] SPACING_RESET  = CSR_W'(6554);
   localparam logic [CSR_W-1:0] MIN_STEP_RESET = CSR_W'(459);
   localparam logic [CSR_W-1:0] MAX_STEP_RESET = CSR_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPACING  = 2'd0,
      CSR_MIN_STEP = 2'd1,
      CSR_MAX_STEP = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_LAUNCH,
      ST_ROOT,
      ST_FILTER,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic signed [POS_W-1:0]     pos_x;
      logic signed [POS_W-1:0]     pos_y;
      logic signed [HEADING_W-1:0] heading;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0]     way_x;
      logic signed [POS_W-1:0]     way_y;
      logic signed [HEADING_W-1:0] way_heading;
      logic [INDEX_W-1:0]          point_index;
   } rsp_item_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_status_type;

   function automatic logic signed [AXIS_W-1:0] sat_axis(input logic signed [DIFF_W-1:0] d);
      logic signed [AXIS_W-1:0] r;
      if ((&d[DIFF_W-1:AXIS_W-1]) || !(|d[DIFF_W-1:AXIS_W-1])) begin
         r = d[AXIS_W-1:0];
      end else if (d[DIFF_W-1]) begin
         r = {1'b1, {(AXIS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(AXIS_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/dwd_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Bit-serial floor square root, one result bit per cycle from the top down.
// ----------------------------------------------------------------------------
module dwd_isqrt
   import dwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_W-1:0]     radicand,
   output sqrt_status_type      status
);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      shifted = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      ge      = (shifted >= trial);

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ge ? (shifted - trial) : shifted;
         root_in = {root_ff[ROOT_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

`ifndef SYNTHESIS
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("square root did not start");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("square root done while still iterating");
   a_fell_done : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff)
      else $error("square root stopped without done");
`endif

endmodule

// File: rtl/distance_waypoint_decimator_unit.sv
// ----------------------------------------------------------------------------
// Distance waypoint decimator
// Thins pose samples to waypoints spaced by travelled distance.
// ----------------------------------------------------------------------------
//  channel  direction  handshake         beat
//  req      in         req_valid/stall   pos_x, pos_y, heading
//  rsp      out        rsp_valid/stall   way_x, way_y, way_heading, point_index
//  csr      in         csr_valid/ready   csr_index, csr_data
//
//  A sample passes from accept to the next accept through the axis
//  differences, the squares of both differences on the shared multiplier,
//  the root launch, the bit-serial square root, the filter and accumulate
//  steps and the return to idle. The first sample after reset skips the arithmetic.
//  Reset is synchronous and restores the register defaults.
//  A waypoint waits in the output register; a new sample is accepted while
//  it waits, and only a second waypoint holds the block until it drains.
// ----------------------------------------------------------------------------
module distance_waypoint_decimator_unit
   import dwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_data
);

   state_type                   state_ff, state_in;
   logic signed [POS_W-1:0]     cur_x_ff, cur_x_in;
   logic signed [POS_W-1:0]     cur_y_ff, cur_y_in;
   logic signed [HEADING_W-1:0] cur_hd_ff, cur_hd_in;
   logic signed [POS_W-1:0]     prev_x_ff, prev_x_in;
   logic signed [POS_W-1:0]     prev_y_ff, prev_y_in;
   logic                        started_ff, started_in;
   logic                        first_ff, first_in;
   logic signed [AXIS_W-1:0]    dx_ff, dx_in;
   logic signed [AXIS_W-1:0]    dy_ff, dy_in;
   logic [RAD_W-1:0]            sq_ff, sq_in;
   logic [ROOT_W-1:0]           step_ff, step_in;
   logic [TRAV_W-1:0]           trav_ff, trav_in;
   logic [INDEX_W-1:0]          count_ff, count_in;
   logic [CSR_W-1:0]            spacing_ff, spacing_in;
   logic [CSR_W-1:0]            min_step_ff, min_step_in;
   logic [CSR_W-1:0]            max_step_ff, max_step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_item_type                rsp_data_ff, rsp_data_in;

   logic signed [DIFF_W-1:0]    diff_x;
   logic signed [DIFF_W-1:0]    diff_y;
   logic signed [AXIS_W-1:0]    mul_a;
   logic signed [RAD_W-1:0]     prod;
   logic [TRAV_W:0]             trav_sum;
   logic [TRAV_W-1:0]           trav_sat;
   logic                        emit_now;
   logic                        out_free;
   logic                        sqrt_start;
   sqrt_status_type             sqrt_status;

   dwd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_ff),
      .status   (sqrt_status)
   );

   assign diff_x   = {cur_x_ff[POS_W-1], cur_x_ff} - {prev_x_ff[POS_W-1], prev_x_ff};
   assign diff_y   = {cur_y_ff[POS_W-1], cur_y_ff} - {prev_y_ff[POS_W-1], prev_y_ff};
   assign mul_a    = (state_ff == ST_SQX) ? dx_ff : dy_ff;
   assign prod     = mul_a * mul_a;
   assign trav_sum = {1'b0, trav_ff} + {{(TRAV_W + 1 - ROOT_W){1'b0}}, step_ff};
   assign trav_sat = trav_sum[TRAV_W] ? {TRAV_W{1'b1}} : trav_sum[TRAV_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_hd_in    = cur_hd_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      started_in   = started_ff;
      first_in     = first_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_in        = sq_ff;
      step_in      = step_ff;
      trav_in      = trav_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      sqrt_start   = 1'b0;
      req_stall    = 1'b1;
      emit_now     = first_ff || (trav_sat >= {{(TRAV_W - CSR_W){1'b0}}, spacing_ff});

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cur_x_in  = req_data.pos_x;
               cur_y_in  = req_data.pos_y;
               cur_hd_in = req_data.heading;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            if (!started_ff) begin
               started_in = 1'b1;
               first_in   = 1'b1;
               state_in   = ST_ACC;
            end else begin
               first_in = 1'b0;
               dx_in    = sat_axis(diff_x);
               dy_in    = sat_axis(diff_y);
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sq_in    = $unsigned(prod);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_in    = sq_ff + $unsigned(prod);
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_status.done) begin
               state_in = ST_FILTER;
            end
         end
         ST_FILTER: begin
            if ((sqrt_status.root < min_step_ff) ||
                ((max_step_ff != '0) && (sqrt_status.root > max_step_ff))) begin
               step_in = '0;
            end else begin
               step_in = sqrt_status.root;
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!emit_now || out_free) begin
               if (!first_ff) begin
                  trav_in = emit_now ? '0 : trav_sat;
               end
               if (emit_now) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.way_x       = cur_x_ff;
                  rsp_data_in.way_y       = cur_y_ff;
                  rsp_data_in.way_heading = cur_hd_ff;
                  rsp_data_in.point_index = count_ff;
                  if (count_ff != {INDEX_W{1'b1}}) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      spacing_in  = spacing_ff;
      min_step_in = min_step_ff;
      max_step_in = max_step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SPACING:  spacing_in  = csr_data;
            CSR_MIN_STEP: min_step_in = csr_data;
            CSR_MAX_STEP: max_step_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      cur_hd_ff   <= cur_hd_in;
      first_ff    <= first_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sq_ff       <= sq_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         started_ff   <= 1'b0;
         trav_ff      <= '0;
         count_ff     <= '0;
         spacing_ff   <= SPACING_RESET;
         min_step_ff  <= MIN_STEP_RESET;
         max_step_ff  <= MAX_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         started_ff   <= started_in;
         trav_ff      <= trav_in;
         count_ff     <= count_in;
         spacing_ff   <= spacing_in;
         min_step_ff  <= min_step_in;
         max_step_ff  <= max_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_sat : assert property (@(posedge clock) disable iff (reset)
      (count_ff == {INDEX_W{1'b1}}) |=> (count_ff == {INDEX_W{1'b1}}))
      else $error("waypoint index wrapped");
   a_emit_src : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_ACC))
      else $error("waypoint beat raised outside accumulate step");
   a_started_holds : assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped without reset");
`endif

endmodule

// File: tb/sv/distance_waypoint_decimator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance waypoint decimator testbench
// Sends pose samples to the decimator in bursts while the waypoint side
// stalls on its own pattern. A scoreboard class keeps its own copy of the
// registers and of the travelled-distance state and predicts every waypoint.
// Each waypoint beat is compared field by field with the oldest prediction.
// A directed part covers the first sample, the deadband and outlier limits,
// saturated axis differences and the ignored register index. Random
// trajectories with noise follow under several register settings.
// ----------------------------------------------------------------------------
module distance_waypoint_decimator_unit_test
   import dwd_pkg::*;
();

   class waypoint_tracker;
      logic [CSR_W-1:0]        spacing;
      logic [CSR_W-1:0]        min_step;
      logic [CSR_W-1:0]        max_step;
      bit                      started;
      logic signed [POS_W-1:0] prev_x;
      logic signed [POS_W-1:0] prev_y;
      logic [TRAV_W-1:0]       travelled;
      logic [INDEX_W-1:0]      emitted_count;
      rsp_item_type            due_waypoints[$];
      int unsigned             samples_seen;
      int unsigned             waypoints_seen;

      function new();
         spacing        = SPACING_RESET;
         min_step       = MIN_STEP_RESET;
         max_step       = MAX_STEP_RESET;
         started        = 1'b0;
         prev_x         = '0;
         prev_y         = '0;
         travelled      = '0;
         emitted_count  = '0;
         samples_seen   = 0;
         waypoints_seen = 0;
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_W-1:0] val);
         case (idx)
            CSR_SPACING:  spacing  = val;
            CSR_MIN_STEP: min_step = val;
            CSR_MAX_STEP: max_step = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_waypoints.size();
      endfunction

      function longint clamp_axis(input logic signed [POS_W:0] d);
         longint hi;
         longint dw;
         hi = (longint'(1) << (AXIS_W - 1)) - 1;
         dw = d;
         if (dw > hi) return hi;
         if (dw < -hi - 1) return -hi - 1;
         return dw;
      endfunction

      function logic [CSR_W-1:0] floor_root(input logic [63:0] v);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] probe;
         rem   = v;
         root  = '0;
         probe = 64'h1 << 62;
         while (probe > rem) probe = probe >> 2;
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem  = rem - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root[CSR_W-1:0];
      endfunction

      function void push_waypoint(input req_item_type s);
         rsp_item_type w;
         w.way_x       = s.pos_x;
         w.way_y       = s.pos_y;
         w.way_heading = s.heading;
         w.point_index = emitted_count;
         if (emitted_count != '1) emitted_count = emitted_count + 1'b1;
         due_waypoints.push_back(w);
      endfunction

      function void note_sample(input req_item_type s);
         logic signed [POS_W:0] dx_full;
         logic signed [POS_W:0] dy_full;
         longint                dx;
         longint                dy;
         logic [63:0]           radius_sq;
         logic [CSR_W-1:0]      step;
         logic [TRAV_W:0]       sum;
         samples_seen++;
         if (!started) begin
            started = 1'b1;
            prev_x  = s.pos_x;
            prev_y  = s.pos_y;
            push_waypoint(s);
            return;
         end
         dx_full   = {s.pos_x[POS_W-1], s.pos_x} - {prev_x[POS_W-1], prev_x};
         dy_full   = {s.pos_y[POS_W-1], s.pos_y} - {prev_y[POS_W-1], prev_y};
         dx        = clamp_axis(dx_full);
         dy        = clamp_axis(dy_full);
         radius_sq = dx * dx + dy * dy;
         step      = floor_root(radius_sq);
         if (step < min_step) step = '0;
         if (max_step != 0 && step > max_step) step = '0;
         sum       = {1'b0, travelled} + step;
         travelled = sum[TRAV_W] ? '1 : sum[TRAV_W-1:0];
         prev_x    = s.pos_x;
         prev_y    = s.pos_y;
         if (travelled >= spacing) begin
            travelled = '0;
            push_waypoint(s);
         end
      endfunction

      function bit check_waypoint(input rsp_item_type got, output string why);
         rsp_item_type want;
         why = "";
         if (due_waypoints.size() == 0) begin
            why = $sformatf("unexpected waypoint x=%0d y=%0d index=%0d",
                            got.way_x, got.way_y, got.point_index);
            return 1'b0;
         end
         want = due_waypoints.pop_front();
         waypoints_seen++;
         if (got.way_x != want.way_x)
            why = {why, $sformatf(" way_x %0d/%0d", got.way_x, want.way_x)};
         if (got.way_y != want.way_y)
            why = {why, $sformatf(" way_y %0d/%0d", got.way_y, want.way_y)};
         if (got.way_heading != want.way_heading)
            why = {why, $sformatf(" way_heading %0d/%0d", got.way_heading,
                                  want.way_heading)};
         if (got.point_index != want.point_index)
            why = {why, $sformatf(" point_index %0d/%0d", got.point_index,
                                  want.point_index)};
         if (why != "") begin
            why = {$sformatf("waypoint %0d mismatch (got/expected):", waypoints_seen), why};
            return 1'b0;
         end
         return 1'b1;
      endfunction
   endclass

   typedef enum int {
      POSE_STEP,
      POSE_RANDOM,
      POSE_HOLD,
      POSE_EXTREME
   } pose_kind_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURSTY
   } stall_mode_type;

   localparam int                   QUIET_LIMIT   = 2000;
   localparam int                   SETTLE_CYCLES = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;
   localparam logic [CSR_W-1:0]     CSR_TOP       = '1;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data  = '0;

   waypoint_tracker tracker = new();

   int                      error_count      = 0;
   int                      settings_applied = 0;
   int                      quiet_cycles     = 0;
   int                      burst_left       = 0;
   logic signed [POS_W-1:0] cur_x            = '0;
   logic signed [POS_W-1:0] cur_y            = '0;
   stall_mode_type          stall_mode       = STALL_NONE;
   int                      mode_left        = 0;
   int                      hold_left        = 0;

   int unsigned             step_span [4] = '{600, 8000, 200000, 9000000};
   logic signed [POS_W-1:0] corner_pos [4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1};

   distance_waypoint_decimator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_error(input string why);
      error_count++;
      if (error_count <= 50) $display("ERROR: %s", why);
   endtask

   always @(posedge clock) begin : rsp_monitor
      string why;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (!tracker.check_waypoint(rsp_data, why)) report_error(why);
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(50, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (hold_left == 0) begin
               rsp_stall <= ~rsp_stall;
               hold_left <= $urandom_range(0, 60);
            end else begin
               hold_left <= hold_left - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("TIMEOUT: no handshake for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Leaves valid high after the beat; the caller lowers it when a gap follows.
   task automatic send_sample(input req_item_type s);
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      tracker.note_sample(s);
   endtask

   task automatic send_pose(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                            input logic signed [HEADING_W-1:0] h);
      req_item_type s;
      s.pos_x   = x;
      s.pos_y   = y;
      s.heading = h;
      cur_x     = x;
      cur_y     = y;
      send_sample(s);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, val);
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] spacing_val,
                                 input logic [CSR_W-1:0] min_val,
                                 input logic [CSR_W-1:0] max_val);
      wait_drain();
      csr_beat(CSR_UNUSED, CSR_W'($urandom));
      csr_beat(CSR_SPACING, spacing_val);
      csr_beat(CSR_MIN_STEP, min_val);
      csr_beat(CSR_MAX_STEP, max_val);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic req_item_type next_pose();
      req_item_type  p;
      pose_kind_type kind;
      int unsigned   roll;
      int unsigned   span;
      roll = $urandom_range(0, 99);
      if (roll < 70) kind = POSE_STEP;
      else if (roll < 85) kind = POSE_RANDOM;
      else if (roll < 93) kind = POSE_HOLD;
      else kind = POSE_EXTREME;
      case (kind)
         POSE_STEP: begin
            span  = step_span[$urandom_range(0, 3)];
            cur_x = cur_x + (int'($urandom_range(0, 2 * span)) - int'(span));
            span  = step_span[$urandom_range(0, 3)];
            cur_y = cur_y + (int'($urandom_range(0, 2 * span)) - int'(span));
         end
         POSE_RANDOM: begin
            cur_x = $urandom;
            cur_y = $urandom;
         end
         POSE_EXTREME: begin
            cur_x = corner_pos[$urandom_range(0, 3)];
            cur_y = corner_pos[$urandom_range(0, 3)];
         end
         default: ;
      endcase
      p.pos_x   = cur_x;
      p.pos_y   = cur_y;
      p.heading = HEADING_W'($urandom);
      return p;
   endfunction

   task automatic run_random(input int count, input bit steady);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 59) == 0) begin
            wait_drain();
         end else if (!steady && burst_left == 0) begin
            idle_cycles($urandom_range(0, 40));
            burst_left = $urandom_range(1, 20);
         end
         send_sample(next_pose());
         if (burst_left > 0) burst_left--;
      end
   endtask

   initial begin : stimulus
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: spacing 0.1 m, deadband 0.007 m, no outlier limit.
      send_pose(32'sd0, 32'sd0, 16'sd0);
      send_pose(32'sd3000, 32'sd0, 16'sh7FFF);
      send_pose(32'sd3000, 32'sd4000, 16'sh8000);
      send_pose(32'sd3100, 32'sd4000, HEADING_W'($urandom));
      send_pose(32'sd3559, 32'sd4000, HEADING_W'($urandom));
      send_pose(32'sd4017, 32'sd4000, HEADING_W'($urandom));
      send_pose(32'sh7FFFFFFF, 32'sh80000000, HEADING_W'($urandom));
      send_pose(32'sh80000000, 32'sh7FFFFFFF, HEADING_W'($urandom));
      send_pose(-32'sd1, -32'sd1, HEADING_W'($urandom));
      send_pose(-32'sd1, -32'sd1, HEADING_W'($urandom));

      // Outlier limit active, no deadband.
      apply_settings(CSR_W'(10000), CSR_W'(0), CSR_W'(5000));
      send_pose(32'sd3999, -32'sd1, HEADING_W'($urandom));
      send_pose(32'sd11999, -32'sd1, HEADING_W'($urandom));
      send_pose(32'sd16999, -32'sd1, HEADING_W'($urandom));
      send_pose(32'sd17999, -32'sd1, HEADING_W'($urandom));

      apply_settings(CSR_W'(1), CSR_W'(0), CSR_W'(0));
      run_random(70, 1'b0);
      apply_settings(CSR_TOP, CSR_W'(0), CSR_W'(0));
      run_random(70, 1'b0);
      apply_settings(CSR_TOP, CSR_TOP, CSR_TOP);
      run_random(25, 1'b0);
      apply_settings(CSR_W'(2000), CSR_W'(100), CSR_W'(3000));
      run_random(80, 1'b0);
      apply_settings(SPACING_RESET, MIN_STEP_RESET, MAX_STEP_RESET);
      run_random(80, 1'b1);
      repeat (3) begin
         apply_settings(CSR_W'($urandom_range(1, 50000)), CSR_W'($urandom_range(0, 3000)),
                        ($urandom_range(0, 1) == 0) ? CSR_W'(0)
                                                    : CSR_W'($urandom_range(2000, CSR_TOP)));
         run_random(75, 1'b0);
      end

      wait_drain();
      $display("Covered %0d pose samples and %0d waypoints over %0d register settings,",
               tracker.samples_seen, tracker.waypoints_seen, settings_applied + 1);
      $display("with bursty sends, drained pauses and random waypoint stalls.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: distance_waypoint_decimator_unit.f
rtl/dwd_pkg.sv
rtl/dwd_isqrt.sv
rtl/distance_waypoint_decimator_unit.sv
tb/sv/distance_waypoint_decimator_unit_test.sv
